>>> rtl/puct_pkg.sv
// Shared widths, constants and the queue entry type for the PUCT child selector.
`timescale 1ns / 1ps
package puct_pkg;

    localparam int PRIOR_W   = 17;
    localparam int VISIT_W   = 32;
    localparam int VALUE_W   = 48;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int IDX_W     = 8;
    localparam int SCORE_W   = 37;
    localparam int ROOT_W    = 32;
    localparam int GP_W      = GAIN_W + PRIOR_W - GAIN_FRAC;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

    localparam int DEF_MAX_CHILDREN = 256;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    typedef struct packed {
        logic [GP_W-1:0]    gain_prior;
        logic [VISIT_W-1:0] child_visits;
        logic [VALUE_W-1:0] child_value_sum;
        logic [VISIT_W-1:0] parent_visits;
        logic               last_child;
        logic               scored;
        logic [IDX_W-1:0]   index;
    } puct_item_t;

endpackage

>>> rtl/puct_if.sv
// Channel interfaces: child input, selection result and gain write.
`timescale 1ns / 1ps
interface puct_in_if;
    logic                           valid;
    logic                           ready;
    logic [puct_pkg::PRIOR_W-1:0]   prior;
    logic [puct_pkg::VISIT_W-1:0]   child_visits;
    logic [puct_pkg::VALUE_W-1:0]   child_value_sum;
    logic [puct_pkg::VISIT_W-1:0]   parent_visits;
    logic                           last_child;

    modport source (output valid, prior, child_visits, child_value_sum, parent_visits,
                    last_child, input ready);
    modport sink (input valid, prior, child_visits, child_value_sum, parent_visits,
                  last_child, output ready);
endinterface

interface puct_out_if;
    logic                           valid;
    logic                           ready;
    logic [puct_pkg::IDX_W-1:0]     selected_child;
    logic [puct_pkg::SCORE_W-1:0]   win_score;

    modport source (output valid, selected_child, win_score, input ready);
    modport sink (input valid, selected_child, win_score, output ready);
endinterface

interface puct_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [puct_pkg::GAIN_W-1:0]    exploration_gain;

    modport source (output valid, exploration_gain, input ready);
    modport sink (input valid, exploration_gain, output ready);
endinterface

>>> rtl/puct_front.sv
// Front end: accept child beats, count positions, form c*P and push to the queue.
`timescale 1ns / 1ps
module puct_front #(
    parameter int MAX_CHILDREN = puct_pkg::DEF_MAX_CHILDREN
) (
    input  logic                clk,
    input  logic                rst_n,
    puct_cfg_if.sink            cfg,
    puct_in_if.sink             child_in,
    input  logic                full,
    output logic                push,
    output puct_pkg::puct_item_t item
);
    localparam int POS_W = $clog2(MAX_CHILDREN + 1);

    logic [puct_pkg::GAIN_W-1:0]                    gain_reg;
    logic [POS_W-1:0]                               pos_reg;
    logic [puct_pkg::GAIN_W+puct_pkg::PRIOR_W-1:0]  gp_full;
    logic [POS_W+puct_pkg::IDX_W-1:0]               pos_wide;
    logic                                           scored;

    assign cfg.ready      = 1'b1;
    assign child_in.ready = !full;
    assign push           = child_in.valid && child_in.ready;

    assign scored   = pos_reg < POS_W'(MAX_CHILDREN);
    assign pos_wide = (POS_W + puct_pkg::IDX_W)'(pos_reg);
    assign gp_full  = (puct_pkg::GAIN_W + puct_pkg::PRIOR_W)'(gain_reg)
                    * (puct_pkg::GAIN_W + puct_pkg::PRIOR_W)'(child_in.prior);

    always_comb
    begin
        item.gain_prior      = gp_full[puct_pkg::GAIN_W+puct_pkg::PRIOR_W-1:puct_pkg::GAIN_FRAC];
        item.child_visits    = child_in.child_visits;
        item.child_value_sum = child_in.child_value_sum;
        item.parent_visits   = child_in.parent_visits;
        item.last_child      = child_in.last_child;
        item.scored          = scored;
        item.index           = pos_wide[puct_pkg::IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= puct_pkg::GAIN_RESET;
            pos_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                gain_reg <= cfg.exploration_gain;
            end
            if (push)
            begin
                if (child_in.last_child)
                begin
                    pos_reg <= '0;
                end
                else if (scored)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

endmodule

>>> rtl/puct_fifo.sv
// Short queue between the front end and the scoring back end.
`timescale 1ns / 1ps
module puct_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  puct_pkg::puct_item_t item_in,
    output logic                 full,
    input  logic                 pop,
    output puct_pkg::puct_item_t item_out,
    output logic                 not_empty
);
    localparam int DEPTH = puct_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    puct_pkg::puct_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign item_out  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != CNT_W'(DEPTH) || pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue pop while empty");

endmodule

>>> rtl/puct_back.sv
// Back end: divide, square root, multiply, score, keep the running best, emit.
`timescale 1ns / 1ps
module puct_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 not_empty,
    input  puct_pkg::puct_item_t item,
    output logic                 pop,
    puct_out_if.source           result
);
    localparam int Q_STEPS = puct_pkg::VALUE_W;
    localparam int E_STEPS = puct_pkg::SCORE_W;
    localparam int CNT_W   = $clog2(Q_STEPS);
    localparam int DVS_W   = puct_pkg::VISIT_W + 1;
    localparam int QV_W    = puct_pkg::VALUE_W + 1;
    localparam int DIFF_W  = QV_W + 1;
    localparam int SREM_W  = puct_pkg::ROOT_W + 2;
    localparam int PAD_W   = puct_pkg::VALUE_W - puct_pkg::SCORE_W;
    localparam int PROD_W  = puct_pkg::GP_W + puct_pkg::ROOT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV_Q  = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV_E  = 3'd3;
    localparam logic [2:0] ST_SCORE  = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;

    localparam logic signed [DIFF_W-1:0] DIFF_MAX =
        {{(DIFF_W-puct_pkg::SCORE_W){1'b0}}, puct_pkg::SCORE_MAX};
    localparam logic signed [DIFF_W-1:0] DIFF_MIN =
        {{(DIFF_W-puct_pkg::SCORE_W){1'b1}}, puct_pkg::SCORE_MIN};

    logic [2:0]                           state_reg;
    logic [CNT_W-1:0]                     cnt_reg;
    logic                                 have_best_reg;
    logic signed [puct_pkg::SCORE_W-1:0]  lead_score_reg;
    logic [puct_pkg::IDX_W-1:0]           best_index_reg;
    logic                                 out_valid_reg;
    logic [puct_pkg::IDX_W-1:0]           out_index_reg;
    logic [puct_pkg::SCORE_W-1:0]         out_score_reg;

    puct_pkg::puct_item_t                 item_reg;
    logic [puct_pkg::VALUE_W-1:0]         quo_reg;
    logic [DVS_W-1:0]                     rem_reg;
    logic [DVS_W-1:0]                     dvs_reg;
    logic [puct_pkg::VISIT_W-1:0]         rad_reg;
    logic [puct_pkg::ROOT_W-1:0]          root_reg;
    logic [SREM_W-1:0]                    srem_reg;
    logic signed [QV_W-1:0]               q_reg;
    logic signed [puct_pkg::SCORE_W-1:0]  sc_reg;

    logic [DVS_W:0]                       rem_sh;
    logic                                 div_ge;
    logic [DVS_W:0]                       rem_sub;
    logic [SREM_W+1:0]                    srem_sh;
    logic [SREM_W+1:0]                    trial;
    logic                                 sq_ge;
    logic [SREM_W+1:0]                    srem_sub;
    logic [puct_pkg::VALUE_W-1:0]         mag_in;
    logic [QV_W-1:0]                      qm_ext;
    logic [PROD_W-1:0]                    prod;
    logic signed [DIFF_W-1:0]             diff;
    logic                                 take;
    logic                                 can_finish;
    logic                                 emit;

    // Restoring divider step, one quotient bit per cycle.
    assign rem_sh  = {rem_reg, quo_reg[puct_pkg::VALUE_W-1]};
    assign div_ge  = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // Digit-by-digit square root step, two radicand bits per cycle.
    assign srem_sh  = {srem_reg, rad_reg[puct_pkg::VISIT_W-1 -: 2]};
    assign trial    = (SREM_W + 2)'({root_reg, 2'b01});
    assign sq_ge    = srem_sh >= trial;
    assign srem_sub = srem_sh - trial;

    assign mag_in = item.child_value_sum[puct_pkg::VALUE_W-1]
                  ? (~item.child_value_sum + puct_pkg::VALUE_W'(1))
                  : item.child_value_sum;
    assign qm_ext = {1'b0, quo_reg};
    assign prod   = PROD_W'(item_reg.gain_prior) * PROD_W'(root_reg);
    assign diff   = $signed(DIFF_W'(quo_reg[puct_pkg::SCORE_W-1:0]))
                  - $signed({q_reg[QV_W-1], q_reg});

    assign take       = item_reg.scored && (!have_best_reg || sc_reg > lead_score_reg);
    assign can_finish = !item_reg.last_child || !out_valid_reg || result.ready;
    assign emit       = (state_reg == ST_UPDATE) && can_finish && item_reg.last_child;
    assign pop        = (state_reg == ST_IDLE) && not_empty;

    assign result.valid          = out_valid_reg;
    assign result.selected_child = out_index_reg;
    assign result.win_score      = out_score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            have_best_reg  <= 1'b0;
            lead_score_reg <= puct_pkg::SCORE_MIN;
            best_index_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_score_reg  <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (not_empty)
                    begin
                        state_reg <= item.scored ? ST_DIV_Q : ST_UPDATE;
                    end
                end
                ST_DIV_Q:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(Q_STEPS - 1))
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV_E;
                end
                ST_DIV_E:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(E_STEPS - 1))
                    begin
                        state_reg <= ST_SCORE;
                    end
                end
                ST_SCORE:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (can_finish)
                    begin
                        state_reg <= ST_IDLE;
                        if (item_reg.last_child)
                        begin
                            out_index_reg  <= take ? item_reg.index : best_index_reg;
                            out_score_reg  <= take ? sc_reg : lead_score_reg;
                            have_best_reg  <= 1'b0;
                            lead_score_reg <= puct_pkg::SCORE_MIN;
                            best_index_reg <= '0;
                        end
                        else if (take)
                        begin
                            have_best_reg  <= 1'b1;
                            lead_score_reg <= sc_reg;
                            best_index_reg <= item_reg.index;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    item_reg <= item;
                    quo_reg  <= mag_in;
                    rem_reg  <= '0;
                    dvs_reg  <= DVS_W'(item.child_visits);
                    rad_reg  <= item.parent_visits;
                    root_reg <= '0;
                    srem_reg <= '0;
                end
            end
            ST_DIV_Q:
            begin
                quo_reg <= {quo_reg[puct_pkg::VALUE_W-2:0], div_ge};
                rem_reg <= div_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                if (cnt_reg < CNT_W'(puct_pkg::ROOT_W))
                begin
                    rad_reg  <= {rad_reg[puct_pkg::VISIT_W-3:0], 2'b00};
                    root_reg <= {root_reg[puct_pkg::ROOT_W-2:0], sq_ge};
                    srem_reg <= sq_ge ? srem_sub[SREM_W-1:0] : srem_sh[SREM_W-1:0];
                end
            end
            ST_MUL:
            begin
                // Zero visits means no value term.
                if (item_reg.child_visits == '0)
                begin
                    q_reg <= '0;
                end
                else if (item_reg.child_value_sum[puct_pkg::VALUE_W-1])
                begin
                    q_reg <= -$signed(qm_ext);
                end
                else
                begin
                    q_reg <= $signed(qm_ext);
                end
                quo_reg <= {prod[PROD_W-1:16], {PAD_W{1'b0}}};
                rem_reg <= '0;
                dvs_reg <= DVS_W'(item_reg.child_visits) + DVS_W'(1);
            end
            ST_DIV_E:
            begin
                quo_reg <= {quo_reg[puct_pkg::VALUE_W-2:0], div_ge};
                rem_reg <= div_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            end
            ST_SCORE:
            begin
                if (diff > DIFF_MAX)
                begin
                    sc_reg <= puct_pkg::SCORE_MAX;
                end
                else if (diff < DIFF_MIN)
                begin
                    sc_reg <= puct_pkg::SCORE_MIN;
                end
                else
                begin
                    sc_reg <= diff[puct_pkg::SCORE_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> !have_best_reg && lead_score_reg == puct_pkg::SCORE_MIN)
        else $error("running best not cleared after a result");
    a_valid_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !$past(out_valid_reg) |-> $past(state_reg) == ST_UPDATE)
        else $error("result raised outside the update step");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg != ST_IDLE)
        else $error("popped item not taken up");

endmodule

>>> rtl/puct_child_select.sv
// Top level of the PUCT child selector: front end, queue and scoring back end.
`timescale 1ns / 1ps
//
//  channel    dir  beat carries
//  cfg        in   exploration_gain (Q4.12), always ready
//  child_in   in   prior, child_visits, child_value_sum, parent_visits, last_child
//  result     out  selected_child, win_score (one beat per last child)
//
//  A scored child passes through the back end in order: the Q division (the square
//  root of the parent count runs alongside), a multiply step, the exploration
//  division, then score, update and the idle pick-up. Both divisions share one
//  restoring divider, which sets the rate. Children past MAX_CHILDREN skip to update.
//  Reset clears the running best, the position count and the queue; gain goes to 1.0.
//  The front end keeps taking children while the two-entry queue has room, and a
//  waiting result in the output register stalls only a later last child.
//
module puct_child_select #(
    parameter int MAX_CHILDREN = puct_pkg::DEF_MAX_CHILDREN
) (
    input  logic        clk,
    input  logic        rst_n,
    puct_cfg_if.sink    cfg,
    puct_in_if.sink     child_in,
    puct_out_if.source  result
);
    puct_pkg::puct_item_t push_item;
    puct_pkg::puct_item_t head_item;
    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 not_empty;

    // Classify and count positions, form c*P once per child.
    puct_front #(
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .child_in (child_in),
        .full     (full),
        .push     (push),
        .item     (push_item)
    );

    // Decouple acceptance from the long scoring run.
    puct_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item_in   (push_item),
        .full      (full),
        .pop       (pop),
        .item_out  (head_item),
        .not_empty (not_empty)
    );

    // Score each child, hold the running best, drive the result register.
    puct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .item      (head_item),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> tb/puct_child_select_tb.sv
// Self-checking testbench for the PUCT child selector: directed table, then random parents.
`timescale 1ns / 1ps
module puct_child_select_tb;

    localparam int     PRIOR_W    = puct_pkg::PRIOR_W;
    localparam int     VISIT_W    = puct_pkg::VISIT_W;
    localparam int     VALUE_W    = puct_pkg::VALUE_W;
    localparam int     GAIN_W     = puct_pkg::GAIN_W;
    localparam int     GAIN_FRAC  = puct_pkg::GAIN_FRAC;
    localparam int     IDX_W      = puct_pkg::IDX_W;
    localparam int     SCORE_W    = puct_pkg::SCORE_W;

    localparam longint SC_HI      = 64'sd68719476735;
    localparam longint SC_LO      = -64'sd68719476736;
    localparam int     CHILD_CAP  = puct_pkg::DEF_MAX_CHILDREN;
    localparam int     SETTLE     = 300;       // several back-end passes
    localparam longint CYCLE_CAP  = 2000000;
    localparam int     HOLD_LEN   = 4000;      // long enough to fill the queue and stall input

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
    } pick_t;

    typedef struct {
        logic [PRIOR_W-1:0] p;
        logic [VISIT_W-1:0] nc;
        logic [VALUE_W-1:0] w;
        logic [VISIT_W-1:0] np;
        logic               last;
        logic               typed;
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
    } row_t;

    logic clk;
    logic rst_n;
    longint cycles;
    int errors;
    logic long_hold;

    puct_cfg_if cfg ();
    puct_in_if  child_in ();
    puct_out_if result ();

    puct_child_select u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .child_in (child_in),
        .result   (result)
    );

    // Predictor state: gain and the running selection of the current parent.
    logic [GAIN_W-1:0]  gain;
    longint             best_sc;
    logic [IDX_W-1:0]   best_idx;
    int                 position;
    logic               have_best;
    pick_t              pending_picks[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Bound the run; a stuck handshake ends here.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("%0t timeout after %0d cycles", $time, cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [63:0] int_root(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Score of one child edge: exploration term minus mean value, saturated.
    function automatic longint edge_score(logic [PRIOR_W-1:0] p, logic [VISIT_W-1:0] nc,
                                          logic [VALUE_W-1:0] w, logic [VISIT_W-1:0] np);
        longint      q;
        longint      sc;
        logic [63:0] mag;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] e;
        q = 0;
        if (nc != 0)
        begin
            mag = w[VALUE_W-1] ? (64'd0 - {{16{1'b1}}, w}) : {16'd0, w};
            q   = longint'(mag / {32'd0, nc});
            if (w[VALUE_W-1])
                q = -q;
        end
        s  = int_root({np, 32'd0});
        t  = ({48'd0, gain} * {47'd0, p}) >> GAIN_FRAC;
        u  = (t * s) >> 16;
        e  = u / ({32'd0, nc} + 64'd1);
        sc = longint'(e) - q;
        if (sc > SC_HI)
            sc = SC_HI;
        if (sc < SC_LO)
            sc = SC_LO;
        return sc;
    endfunction

    function automatic void clear_selection();
        best_sc   = SC_LO;
        best_idx  = '0;
        position  = 0;
        have_best = 1'b0;
    endfunction

    // Advance the selection by one accepted child; return 1 with the pick on a last child.
    function automatic logic select_child(row_t r, output pick_t pk);
        longint sc;
        if (position < CHILD_CAP)
        begin
            sc = edge_score(r.p, r.nc, r.w, r.np);
            if (!have_best || sc > best_sc)
            begin
                best_sc   = sc;
                best_idx  = position[IDX_W-1:0];
                have_best = 1'b1;
            end
            position++;
        end
        if (!r.last)
            return 1'b0;
        pk.idx   = best_idx;
        pk.score = best_sc[SCORE_W-1:0];
        clear_selection();
        return 1'b1;
    endfunction

    // Result side: random stall per beat, one long hold-off on request.
    initial
    begin
        int    gap;
        pick_t want;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (long_hold)
            begin
                gap       = HOLD_LEN;
                long_hold = 1'b0;
            end
            if (gap > 0)
            begin
                result.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            result.ready = 1'b1;
            do
                @(posedge clk);
            while (!result.valid);
            if (pending_picks.size() == 0)
            begin
                $display("%0t unexpected result idx=%0d score=%h", $time,
                         result.selected_child, result.win_score);
                errors++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (result.selected_child !== want.idx)
                begin
                    $display("%0t selected_child expected %0d actual %0d", $time,
                             want.idx, result.selected_child);
                    errors++;
                end
                if (result.win_score !== want.score)
                begin
                    $display("%0t win_score expected %h actual %h", $time,
                             want.score, result.win_score);
                    errors++;
                end
            end
        end
    end

    // Offer one child beat; entered and left at a falling edge.
    task automatic send_child(row_t r);
        int    gap;
        pick_t pk;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            child_in.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        child_in.prior           = r.p;
        child_in.child_visits    = r.nc;
        child_in.child_value_sum = r.w;
        child_in.parent_visits   = r.np;
        child_in.last_child      = r.last;
        child_in.valid           = 1'b1;
        do
            @(posedge clk);
        while (!child_in.ready);
        if (select_child(r, pk))
        begin
            if (r.typed)
            begin
                pk.idx   = r.idx;
                pk.score = r.score;
            end
            pending_picks.insert(pending_picks.size(), pk);
        end
        @(negedge clk);
    endtask

    // Drop valid, wait out every pick plus the back end's tail.
    task automatic drain();
        child_in.valid = 1'b0;
        while (pending_picks.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] g);
        cfg.exploration_gain = g;
        cfg.valid            = 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        gain = g;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    function automatic logic [VISIT_W-1:0] pick_visits();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return $urandom_range(1, 20);
            2: return $urandom_range(1, 5000);
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = VALUE_W'({$urandom, $urandom} & 64'h0000_0000_0001_FFFF);
            1: v = 48'd0 - ({16'd0, $urandom} & 48'h0000_0003_FFFF);
            2: v = 48'h8000_0000_0000;
            3: v = 48'h7FFF_FFFF_FFFF;
            default: v = VALUE_W'({$urandom, $urandom});
        endcase
        return v;
    endfunction

    function automatic logic [PRIOR_W-1:0] pick_prior();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 17'd65536;
            2: return PRIOR_W'($urandom);
            default: return PRIOR_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Random parents: mostly short child lists, now and then one past the child cap.
    task automatic run_parents(int items);
        int   sent;
        int   kids;
        row_t r;
        sent = 0;
        while (sent < items)
        begin
            kids = $urandom_range(0, 60) == 0 ? $urandom_range(257, 300)
                                              : $urandom_range(1, 8);
            r.np    = $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom;
            r.typed = 1'b0;
            for (int k = 0; k < kids; k++)
            begin
                // repeat the previous child now and then to make ties
                if (k == 0 || $urandom_range(0, 9) != 0)
                begin
                    r.p  = pick_prior();
                    r.nc = pick_visits();
                    r.w  = pick_value();
                end
                r.last = (k == kids - 1);
                send_child(r);
                sent++;
            end
        end
    endtask

    row_t plan[$];

    initial
    begin
        errors    = 0;
        long_hold = 1'b0;
        gain      = puct_pkg::GAIN_RESET;
        clear_selection();
        rst_n                    = 1'b0;
        cfg.valid                = 1'b0;
        cfg.exploration_gain     = '0;
        child_in.valid           = 1'b0;
        child_in.prior           = '0;
        child_in.child_visits    = '0;
        child_in.child_value_sum = '0;
        child_in.parent_visits   = '0;
        child_in.last_child      = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        //           p          nc            w                   np          last typ idx score
        plan = '{
            '{17'd0,      32'd0,        48'd0,              32'd0,        1, 1, 0, '0},
            '{17'd0,      32'd1,        48'h8000_0000_0000, 32'd0,        1, 1, 0,
              puct_pkg::SCORE_MAX},
            '{17'd0,      32'd1,        48'h7FFF_FFFF_FFFF, 32'd0,        1, 1, 0,
              puct_pkg::SCORE_MIN},
            '{17'd0,      32'd0,        48'd0,              32'd9,        0, 0, 0, '0},
            '{17'd0,      32'd0,        48'd0,              32'd9,        1, 1, 0, '0},
            '{17'd65536,  32'd0,        48'd0,              32'hFFFFFFFF, 0, 0, 0, '0},
            '{17'h1FFFF,  32'd0,        48'd0,              32'hFFFFFFFF, 0, 0, 0, '0},
            '{17'd1,      32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFFFFFF, 0, 0, 0, '0},
            '{17'd65536,  32'd3,        48'h0000_0000_FFFF, 32'hFFFFFFFF, 1, 0, 0, '0},
            '{17'h1FFFF,  32'd0,        48'd0,              32'hFFFFFFFF, 1, 0, 0, '0},
            '{17'd32768,  32'd1,        48'h7FFF_FFFF_FFFF, 32'd100,      0, 0, 0, '0},
            '{17'd32768,  32'd2,        48'h0000_0001_0000, 32'd100,      0, 0, 0, '0},
            '{17'd16384,  32'd0,        48'd0,              32'd100,      1, 0, 0, '0}
        };
        foreach (plan[i])
            send_child(plan[i]);
        drain();

        // max gain; park the result side for a long stretch while children keep coming
        write_gain('1);
        long_hold = 1'b1;
        run_parents(300);
        drain();

        write_gain('0);
        run_parents(150);
        drain();

        write_gain(GAIN_W'($urandom_range(1, 65534)));
        run_parents(250);
        drain();

        write_gain(puct_pkg::GAIN_RESET);
        run_parents(240);
        drain();

        if (errors == 0 && pending_picks.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/puct_pkg.sv
rtl/puct_if.sv
rtl/puct_front.sv
rtl/puct_fifo.sv
rtl/puct_back.sv
rtl/puct_child_select.sv
tb/puct_child_select_tb.sv
